// ===== src/rpcc_pkg.sv =====
// ----------------------------------------------------------------------------
// rpcc_pkg
// Shared types and constants for the RDMA receive PSN check / CNP pacing block.
// ----------------------------------------------------------------------------
package rpcc_pkg;

    // Fixed field widths
    localparam int SRC_QP_W  = 8;
    localparam int DEST_QP_W = 24;
    localparam int PSN_W     = 24;
    localparam int NOW_W     = 48;
    localparam int KIND_W    = 2;

    // Pacing interval after reset: 50 us in ns
    localparam logic [PSN_W-1:0] CNP_INTERVAL_RESET = 24'd50000;

    // Reply packet types
    typedef enum logic [KIND_W-1:0] {
        KIND_CNP  = 2'd0,
        KIND_ACK  = 2'd1,
        KIND_NACK = 2'd2
    } reply_kind_t;

    // Controller states
    typedef enum logic {
        ST_IDLE,
        ST_EVAL
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;   // capture header, start table read
        logic eval_go;  // evaluate, update table, load replies
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free; // reply registers can take a new pair this cycle
    } dp_status_t;

endpackage

// ===== src/rdma_receive_psn_check_cnp_unit.sv =====
// ----------------------------------------------------------------------------
// rdma_receive_psn_check_cnp_unit
// RC receive-side PSN check with per-flow CNP pacing.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one data packet header per item.
//   Output channel (out_valid / out_stall) gives 0, 1 or 2 reply items per
//   header, in order CNP then ACK/NACK; last_reply marks the final one.
//   cfg_wr_en / cfg_wr_data write the CNP pacing interval in ns; write only
//   while the block is idle.
// Timing:
//   A header is accepted, the flow table is read at that edge into registers,
//   and the EVAL state then evaluates it once the reply registers are free;
//   that evaluation registers the first reply on the outputs.
//   A header is taken only after the previous one is evaluated, as set by
//   the registered table read and the evaluate step; a second reply follows.
// Reset:
//   All flows start with expected PSN 0 and last CNP time 0 (per-entry valid
//   bits, no clearing pass); the interval returns to 50000 ns.
// Stall:
//   A stalled reply holds. The next header is still taken while a reply
//   waits; it is held in evaluation until the pending slot is empty and the
//   front reply is either empty or leaving.
// ----------------------------------------------------------------------------
module rdma_receive_psn_check_cnp_unit #(
    parameter int NUM_QP    = 256,
    parameter int TIME_BITS = 48
) (
    input  logic                               clk,
    input  logic                               rst_n,
    // header channel
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [rpcc_pkg::SRC_QP_W-1:0]      source_qp,
    input  logic [rpcc_pkg::DEST_QP_W-1:0]     dest_qp,
    input  logic [rpcc_pkg::PSN_W-1:0]         packet_psn,
    input  logic                               ecn_ce,
    input  logic                               ack_request,
    input  logic [rpcc_pkg::NOW_W-1:0]         now_ns,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [rpcc_pkg::PSN_W-1:0]         cfg_wr_data,
    // reply channel
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [rpcc_pkg::KIND_W-1:0]        reply_kind,
    output logic [rpcc_pkg::SRC_QP_W-1:0]      reply_dest_qp,
    output logic [rpcc_pkg::DEST_QP_W-1:0]     reply_src_qp,
    output logic [rpcc_pkg::PSN_W-1:0]         reply_psn,
    output logic                               last_reply
);

    rpcc_pkg::ctrl_cmd_t  cmd;
    rpcc_pkg::dp_status_t status;

    // Controller
    rpcc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .status   (status),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    // Datapath
    rpcc_dp #(
        .NUM_QP    (NUM_QP),
        .TIME_BITS (TIME_BITS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .source_qp     (source_qp),
        .dest_qp       (dest_qp),
        .packet_psn    (packet_psn),
        .ecn_ce        (ecn_ce),
        .ack_request   (ack_request),
        .now_ns        (now_ns),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .reply_kind    (reply_kind),
        .reply_dest_qp (reply_dest_qp),
        .reply_src_qp  (reply_src_qp),
        .reply_psn     (reply_psn),
        .last_reply    (last_reply)
    );

endmodule

// ===== src/rpcc_ctrl.sv =====
// ----------------------------------------------------------------------------
// rpcc_ctrl
// Controller: one header at a time, read the flow table, then evaluate.
// ----------------------------------------------------------------------------
module rpcc_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  rpcc_pkg::dp_status_t status,
    output rpcc_pkg::ctrl_cmd_t  cmd,
    output logic                 in_stall
);

    rpcc_pkg::state_t state_reg;
    rpcc_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rpcc_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next  = state_reg;
        cmd.accept  = 1'b0;
        cmd.eval_go = 1'b0;
        in_stall    = 1'b1;
        unique case (state_reg)
            rpcc_pkg::ST_IDLE:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
                if (in_valid)
                begin
                    state_next = rpcc_pkg::ST_EVAL;
                end
            end
            rpcc_pkg::ST_EVAL:
            begin
                // wait until the reply registers can take this item's replies
                if (status.out_free)
                begin
                    cmd.eval_go = 1'b1;
                    state_next  = rpcc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rpcc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== src/rpcc_dp.sv =====
// ----------------------------------------------------------------------------
// rpcc_dp
// Datapath: header capture, per-flow table, PSN/CNP evaluation, reply regs.
// ----------------------------------------------------------------------------
module rpcc_dp #(
    parameter int NUM_QP    = 256,
    parameter int TIME_BITS = 48
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  rpcc_pkg::ctrl_cmd_t                cmd,
    output rpcc_pkg::dp_status_t               status,
    // header fields
    input  logic [rpcc_pkg::SRC_QP_W-1:0]      source_qp,
    input  logic [rpcc_pkg::DEST_QP_W-1:0]     dest_qp,
    input  logic [rpcc_pkg::PSN_W-1:0]         packet_psn,
    input  logic                               ecn_ce,
    input  logic                               ack_request,
    input  logic [rpcc_pkg::NOW_W-1:0]         now_ns,
    // configuration
    input  logic                               cfg_wr_en,
    input  logic [rpcc_pkg::PSN_W-1:0]         cfg_wr_data,
    // replies
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [rpcc_pkg::KIND_W-1:0]        reply_kind,
    output logic [rpcc_pkg::SRC_QP_W-1:0]      reply_dest_qp,
    output logic [rpcc_pkg::DEST_QP_W-1:0]     reply_src_qp,
    output logic [rpcc_pkg::PSN_W-1:0]         reply_psn,
    output logic                               last_reply
);

    // Only 2^SRC_QP_W flows can be addressed by an 8-bit source QP
    localparam int SRC_SPAN  = 1 << rpcc_pkg::SRC_QP_W;
    localparam int MEM_DEPTH = (NUM_QP < SRC_SPAN) ? NUM_QP : SRC_SPAN;
    localparam int IDX_W     = $clog2(MEM_DEPTH);
    localparam int TW        = (TIME_BITS < rpcc_pkg::NOW_W) ? TIME_BITS : rpcc_pkg::NOW_W;
    localparam int WORD_W    = rpcc_pkg::PSN_W + TW;

    // Configuration register
    logic [rpcc_pkg::PSN_W-1:0] cnp_interval_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnp_interval_reg <= rpcc_pkg::CNP_INTERVAL_RESET;
        end
        else if (cfg_wr_en)
        begin
            cnp_interval_reg <= cfg_wr_data;
        end
    end

    // Table index: source_qp mod depth, from a constant lookup over all QPs
    logic [IDX_W-1:0] idx_lut [SRC_SPAN];
    logic [IDX_W-1:0] idx_in;

    for (genvar g = 0; g < SRC_SPAN; g++)
    begin : g_idx_lut
        assign idx_lut[g] = IDX_W'(g % MEM_DEPTH);
    end

    assign idx_in = idx_lut[source_qp];

    // Header capture
    logic [rpcc_pkg::SRC_QP_W-1:0]  src_reg;
    logic [rpcc_pkg::DEST_QP_W-1:0] dqp_reg;
    logic [rpcc_pkg::PSN_W-1:0]     psn_reg;
    logic                           ce_reg;
    logic                           ackq_reg;
    logic [TW-1:0]                  now_reg;
    logic [IDX_W-1:0]               idx_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            src_reg  <= source_qp;
            dqp_reg  <= dest_qp;
            psn_reg  <= packet_psn;
            ce_reg   <= ecn_ce;
            ackq_reg <= ack_request;
            now_reg  <= now_ns[TW-1:0];
            idx_reg  <= idx_in;
        end
    end

    // Flow table: {expected_psn, last_cnp_time}; invalid entries read as zero
    logic [WORD_W-1:0]    mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] valid_reg;
    logic [WORD_W-1:0]    rd_word_reg;
    logic                 rd_valid_reg;
    logic [WORD_W-1:0]    wr_word;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            rd_word_reg <= mem[idx_in];
        end
        if (cmd.eval_go)
        begin
            mem[idx_reg] <= wr_word;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                rd_valid_reg <= valid_reg[idx_in];
            end
            if (cmd.eval_go)
            begin
                valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    // Evaluation
    logic [rpcc_pkg::PSN_W-1:0] exp_rd;
    logic [TW-1:0]              last_rd;
    logic [TW-1:0]              elapsed;
    logic                       send_cnp;
    logic                       psn_gt;
    logic                       psn_eq;
    logic                       send_psn;
    rpcc_pkg::reply_kind_t      psn_kind;
    logic [rpcc_pkg::PSN_W-1:0] psn_val;
    logic [rpcc_pkg::PSN_W-1:0] exp_upd;
    logic [TW-1:0]              last_upd;

    always_comb
    begin
        exp_rd   = rd_valid_reg ? rd_word_reg[WORD_W-1:TW] : '0;
        last_rd  = rd_valid_reg ? rd_word_reg[TW-1:0] : '0;
        elapsed  = now_reg - last_rd;
        // time going backwards never sends a CNP
        send_cnp = ce_reg && (now_reg >= last_rd) && (elapsed >= TW'(cnp_interval_reg));
        psn_gt   = psn_reg > exp_rd;
        psn_eq   = psn_reg == exp_rd;
        send_psn = psn_gt || (psn_eq && ackq_reg);
        psn_kind = psn_gt ? rpcc_pkg::KIND_NACK : rpcc_pkg::KIND_ACK;
        psn_val  = psn_gt ? exp_rd : psn_reg;
        exp_upd  = psn_eq ? exp_rd + {{(rpcc_pkg::PSN_W-1){1'b0}}, 1'b1} : exp_rd;
        last_upd = send_cnp ? now_reg : last_rd;
        wr_word  = {exp_upd, last_upd};
    end

    // Reply registers: front item plus one pending reply
    logic                           out_valid_reg, out_valid_next;
    rpcc_pkg::reply_kind_t          out_kind_reg, out_kind_next;
    logic [rpcc_pkg::SRC_QP_W-1:0]  out_dqp_reg, out_dqp_next;
    logic [rpcc_pkg::DEST_QP_W-1:0] out_sqp_reg, out_sqp_next;
    logic [rpcc_pkg::PSN_W-1:0]     out_psn_reg, out_psn_next;
    logic                           out_last_reg, out_last_next;
    logic                           pend_valid_reg, pend_valid_next;
    rpcc_pkg::reply_kind_t          pend_kind_reg, pend_kind_next;
    logic [rpcc_pkg::PSN_W-1:0]     pend_psn_reg, pend_psn_next;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_dqp_next    = out_dqp_reg;
        out_sqp_next    = out_sqp_reg;
        out_psn_next    = out_psn_reg;
        out_last_next   = out_last_reg;
        pend_valid_next = pend_valid_reg;
        pend_kind_next  = pend_kind_reg;
        pend_psn_next   = pend_psn_reg;
        priority if (cmd.eval_go && (send_cnp || send_psn))
        begin
            // when both are sent, CNP goes first, the ACK/NACK waits in the pending slot
            out_valid_next  = 1'b1;
            out_kind_next   = send_cnp ? rpcc_pkg::KIND_CNP : psn_kind;
            out_psn_next    = send_cnp ? '0 : psn_val;
            out_last_next   = !(send_cnp && send_psn);
            out_dqp_next    = src_reg;
            out_sqp_next    = dqp_reg;
            pend_valid_next = send_cnp && send_psn;
            pend_kind_next  = psn_kind;
            pend_psn_next   = psn_val;
        end
        else if (out_valid_reg && !out_stall)
        begin
            if (pend_valid_reg)
            begin
                out_kind_next   = pend_kind_reg;
                out_psn_next    = pend_psn_reg;
                out_last_next   = 1'b1;
                pend_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else
        begin
            // nothing moves, registers hold
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_kind_reg  <= out_kind_next;
        out_dqp_reg   <= out_dqp_next;
        out_sqp_reg   <= out_sqp_next;
        out_psn_reg   <= out_psn_next;
        out_last_reg  <= out_last_next;
        pend_kind_reg <= pend_kind_next;
        pend_psn_reg  <= pend_psn_next;
    end

    // Status and ports
    assign status.out_free = !pend_valid_reg && (!out_valid_reg || !out_stall);

    assign out_valid     = out_valid_reg;
    assign reply_kind    = out_kind_reg;
    assign reply_dest_qp = out_dqp_reg;
    assign reply_src_qp  = out_sqp_reg;
    assign reply_psn     = out_psn_reg;
    assign last_reply    = out_last_reg;

endmodule

// ===== src/rpcc_checker.sv =====
// ----------------------------------------------------------------------------
// rpcc_checker
// Port-level checks for the PSN check / CNP pacing block.
// ----------------------------------------------------------------------------
module rpcc_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic [rpcc_pkg::KIND_W-1:0]        reply_kind,
    input logic [rpcc_pkg::SRC_QP_W-1:0]      reply_dest_qp,
    input logic [rpcc_pkg::DEST_QP_W-1:0]     reply_src_qp,
    input logic [rpcc_pkg::PSN_W-1:0]         reply_psn,
    input logic                               last_reply
);

    // Stalled reply holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(reply_kind)
            && $stable(reply_dest_qp) && $stable(reply_src_qp)
            && $stable(reply_psn) && $stable(last_reply)))
        else $error("stalled reply changed");

    // One header in flight: accept is followed by a stalled cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("header accepted in back-to-back cycles");

    // CNP carries a zero PSN
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (reply_kind == rpcc_pkg::KIND_CNP)) |-> (reply_psn == '0))
        else $error("CNP with nonzero PSN");

    // ACK or NACK is always the last reply of its header
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (reply_kind != rpcc_pkg::KIND_CNP)) |-> last_reply)
        else $error("ACK/NACK not marked last");

endmodule

bind rdma_receive_psn_check_cnp_unit rpcc_checker u_rpcc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .reply_kind    (reply_kind),
    .reply_dest_qp (reply_dest_qp),
    .reply_src_qp  (reply_src_qp),
    .reply_psn     (reply_psn),
    .last_reply    (last_reply)
);
